// File: hw/rtl/piecewise_linear_table_interp_macros.svh
// Assertion macros shared by the breakpoint table RTL.
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PLTI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PLTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/plti_pkg.sv
// Package with the types and constants of the breakpoint table block.
`timescale 1ns / 1ps
package plti_pkg;
  localparam int NumTables = 8;
  localparam int MaxPoints = 256;
  localparam int TblW = 3;
  localparam int PtW = 8;
  localparam int CntW = 9;
  localparam int AddrW = TblW + PtW;
  localparam logic [31:0] OneQ16 = 32'h0001_0000;

  localparam logic [1:0] OpAppend = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_LAST, S_SCAN, S_MUL, S_DIV, S_DONE
  } state_t;

  // Request from the controller to the divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  // Answer from the divider.
  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;
endpackage

// File: hw/rtl/plti_div.sv
// Iterative 64 by 32 divider, signed dividend and unsigned divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module plti_div (
  input  logic               clk,
  input  logic               rst_n,
  input  plti_pkg::div_req_t req,
  output plti_pkg::div_rsp_t rsp
);
  import plti_pkg::*;
  `include "piecewise_linear_table_interp_macros.svh"

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [64:0] shifted;
  logic [64:0] diff;

  assign shifted = {rem_r, quo_r[63]};
  assign diff = shifted - {33'd0, den_r};

  // Restoring division on magnitudes; the sign is restored at the end.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 7'd0;
      rem_nxt = 64'd0;
      quo_nxt = req.num[63] ? (~req.num + 64'd1) : req.num;
      den_nxt = req.den;
      neg_nxt = req.num[63];
    end else if (busy_r) begin
      quo_nxt = {quo_r[62:0], ~diff[64]};
      rem_nxt = diff[64] ? shifted[63:0] : diff[63:0];
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo = neg_r ? (~quo_r[31:0] + 32'd1) : quo_r[31:0];

  `PLTI_ASSERT_NEXT(a_done_ends_busy, clk, rst_n, rsp.done, !busy_r, "done while busy")
  `PLTI_ASSERT_IMP(a_no_start_busy, clk, rst_n, req.start, !busy_r, "start while busy")
  `PLTI_ASSERT_IMP(a_den_nonzero, clk, rst_n, req.start, req.den != 32'd0, "zero divisor")
endmodule

// File: hw/rtl/plti_store.sv
// Breakpoint memory: time and value words in one synchronous RAM.
`timescale 1ns / 1ps
module plti_store (
  input  logic                     clk,
  input  logic                     we,
  input  logic [plti_pkg::AddrW-1:0] waddr,
  input  logic [63:0]              wdata,
  input  logic [plti_pkg::AddrW-1:0] raddr,
  output logic [63:0]              rdata
);
  import plti_pkg::*;
  localparam int Depth = NumTables * MaxPoints;

  logic [63:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/piecewise_linear_table_interp.sv
// Top level of the piecewise-linear breakpoint table block.
`timescale 1ns / 1ps
// Piecewise-linear breakpoint tables with Q16.16 interpolation.
// Input channel in_*: one item per transfer, op append, query or clear.
// Result channel out_*: exactly one result per item, result_value and status.
// Both channels transfer when valid is high and stall is low.
// One item is processed at a time; in_stall is high while it is in work.
// Append, clear and trivial queries present their result in the cycle after
// the input transfer; the next item is taken once that result has transferred.
// A query reads the first and last breakpoints; if the time lies within them it
// scans the table one breakpoint per cycle through the single memory read port
// (up to 256) and, unless a breakpoint matches exactly, forms the 64-bit
// numerator over two multiply steps and divides with an iterative unit of 64
// steps.
// The finished result sits in an output register until out_stall drops,
// after which the next item is taken.
// Reset clears the per-table counts so all tables read as empty; the
// breakpoint memory is not cleared and needs no clearing pass.
// While the receiver stalls, the result holds and no new item is taken.
module piecewise_linear_table_interp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [2:0]  in_table_index,
  input  logic        in_no_function,
  input  logic signed [31:0] in_time_point,
  input  logic signed [31:0] in_point_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_result_value,
  output logic [1:0]  out_status
);
  import plti_pkg::*;
  `include "piecewise_linear_table_interp_macros.svh"

  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r [NumTables];
  logic [TblW-1:0] tbl_r, tbl_nxt;
  logic [CntW-1:0] n_r, n_nxt;
  logic [PtW-1:0] idx_r, idx_nxt;
  logic signed [31:0] t_r, t_nxt;
  logic signed [31:0] tp_r, tp_nxt, vp_r, vp_nxt, tc_r, tc_nxt, vc_r, vc_nxt;
  logic signed [63:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic        mstep_r, mstep_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [31:0] oval_r, oval_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic        we;
  logic [AddrW-1:0] waddr, raddr;
  logic [63:0] rdata;
  logic signed [31:0] rd_t, rd_v;
  logic [CntW-1:0] cur_n;
  div_req_t dreq;
  div_rsp_t drsp;
  logic accept;

  plti_store u_store (
    .clk(clk), .we(we), .waddr(waddr),
    .wdata({in_time_point, in_point_value}), .raddr(raddr), .rdata(rdata)
  );

  plti_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign rd_t = rdata[63:32];
  assign rd_v = rdata[31:0];
  assign in_stall = (state_r != S_IDLE) || ovalid_r;
  assign accept = in_valid && !in_stall;
  assign cur_n = cnt_r[in_table_index];
  assign we = accept && (in_op == OpAppend) && (cur_n < CntW'(MaxPoints));
  assign waddr = {in_table_index, cur_n[PtW-1:0]};

  // Read address: first entry, then last, then the scan index.
  always_comb begin
    raddr = {tbl_r, idx_r};
    if (accept) begin
      raddr = {in_table_index, {PtW{1'b0}}};
    end else if (state_r == S_FIRST) begin
      raddr = {tbl_r, PtW'(n_r - CntW'(1))};
    end
  end

  // Controller: next state and datapath registers.
  always_comb begin
    state_nxt = state_r;
    tbl_nxt = tbl_r; n_nxt = n_r; idx_nxt = idx_r; t_nxt = t_r;
    tp_nxt = tp_r; vp_nxt = vp_r; tc_nxt = tc_r; vc_nxt = vc_r;
    pa_nxt = pa_r; pb_nxt = pb_r; mstep_nxt = mstep_r;
    ovalid_nxt = ovalid_r; oval_nxt = oval_r; ost_nxt = ost_r;
    dreq.start = 1'b0;
    dreq.num = pa_r + pb_r;
    dreq.den = tc_r - tp_r;
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          tbl_nxt = in_table_index;
          n_nxt = cur_n;
          t_nxt = in_time_point;
          idx_nxt = PtW'(0);
          oval_nxt = 32'd0;
          ost_nxt = StOk;
          case (in_op)
            OpAppend: begin
              if (cur_n >= CntW'(MaxPoints)) ost_nxt = StRange;
              ovalid_nxt = 1'b1;
            end
            OpQuery: begin
              if (in_no_function) begin
                oval_nxt = OneQ16;
                ovalid_nxt = 1'b1;
              end else if (cur_n == CntW'(0)) begin
                ost_nxt = StEmpty;
                ovalid_nxt = 1'b1;
              end else begin
                state_nxt = S_FIRST;
              end
            end
            default: ovalid_nxt = 1'b1;
          endcase
        end
      end
      S_FIRST: begin
        if (t_r < rd_t) begin
          ost_nxt = StRange;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (t_r > rd_t) begin
          oval_nxt = rd_v;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
          idx_nxt = PtW'(1);
        end
        tc_nxt = 32'sd0;
      end
      S_SCAN: begin
        // Entry idx_r-1 is on the read port this cycle.
        n_nxt = n_r;
        if (t_r == rd_t) begin
          oval_nxt = rd_v;
          state_nxt = S_DONE;
        end else if (t_r < rd_t) begin
          tc_nxt = rd_t;
          vc_nxt = rd_v;
          mstep_nxt = 1'b0;
          state_nxt = S_MUL;
        end else begin
          tp_nxt = rd_t;
          vp_nxt = rd_v;
          idx_nxt = idx_r + PtW'(1);
        end
      end
      S_MUL: begin
        n_nxt = n_r;
        if (!mstep_r) begin
          pa_nxt = (64'(tc_r) - 64'(t_r)) * 64'(vp_r);
          mstep_nxt = 1'b1;
        end else begin
          pb_nxt = (64'(t_r) - 64'(tp_r)) * 64'(vc_r);
          state_nxt = S_DIV;
          mstep_nxt = 1'b0;
        end
      end
      S_DIV: begin
        n_nxt = n_r;
        if (!mstep_r) begin
          dreq.start = 1'b1;
          mstep_nxt = 1'b1;
        end else if (drsp.done) begin
          oval_nxt = drsp.quo;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        n_nxt = n_r;
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, counts and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      for (int k = 0; k < NumTables; k++) cnt_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      if (accept && in_op == OpAppend && we) begin
        cnt_r[in_table_index] <= cur_n + CntW'(1);
      end else if (accept && in_op == OpClear) begin
        cnt_r[in_table_index] <= '0;
      end
    end
    tbl_r <= tbl_nxt; n_r <= n_nxt; idx_r <= idx_nxt; t_r <= t_nxt;
    tp_r <= tp_nxt; vp_r <= vp_nxt; tc_r <= tc_nxt; vc_r <= vc_nxt;
    pa_r <= pa_nxt; pb_r <= pb_nxt; mstep_r <= mstep_nxt;
    oval_r <= oval_nxt; ost_r <= ost_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_result_value = oval_r;
  assign out_status = ost_r;

  `PLTI_ASSERT_IMP(a_busy_no_out, clk, rst_n, state_r != S_IDLE && state_r != S_DONE, !ovalid_r, "result during work")
  `PLTI_ASSERT_NEXT(a_accept_work, clk, rst_n, accept, ovalid_r || state_r == S_FIRST, "lost")
  `PLTI_ASSERT_IMP(a_cnt_bound, clk, rst_n, state_r != S_IDLE, cnt_r[tbl_r] <= CntW'(MaxPoints), "count")
endmodule
